// File: sv/pcr_pkg.sv
package pcr_pkg;

  // Rotation unit: 30 steps, sine and cosine in signed Q2.30.
  localparam int TRIG_STEPS = 30;
  localparam int TRIG_W = 32;
  localparam int RES_W = 33;
  localparam int FRAC = 30;
  // Products are split at this bit of the coordinate magnitude.
  localparam int SPLIT = 25;

  localparam logic signed [TRIG_W-1:0] TRIG_ONE_K = 32'sd652032874;
  localparam logic signed [RES_W-1:0] QUARTER = 33'sd1073741824;
  localparam logic signed [RES_W-1:0] HALF = 33'sd2147483648;

  // atan(2^-i) in 32-bit binary-angle units.
  localparam logic signed [RES_W-1:0] ATAN_TAB [TRIG_STEPS] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331, 33'sd21354465, 33'sd10679838, 33'sd5340245,
    33'sd2670163, 33'sd1335087, 33'sd667544, 33'sd333772,
    33'sd166886, 33'sd83443, 33'sd41722, 33'sd20861,
    33'sd10430, 33'sd5215, 33'sd2608, 33'sd1304,
    33'sd652, 33'sd326, 33'sd163, 33'sd81,
    33'sd41, 33'sd20, 33'sd10, 33'sd5,
    33'sd3, 33'sd1
  };

  typedef enum logic {
    OP_APPLY  = 1'b0,
    OP_RELATE = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [RES_W-1:0]  z;
    logic                     flip;
  } cordic_t;

endpackage

// File: sv/pose_compose_and_relate.sv
// Channel  Handshake                      Payload
// in       s_axis_tvalid / s_axis_tready  tdata: base pose and operand; tuser: op
// out      m_axis_tvalid / m_axis_tready  tdata: out_x, out_y, out_z, out_angle
//
// One item per cycle while s_axis_tready is high; an item passes one entry stage, 30
// rotation steps of one stage each, two multiplier stages, then the final sum and
// saturation into the output register.
// Reset clears all valid bits, including those of the output buffer; data registers keep their value.
// When the output is not taken, one more result moves into a spare register and then
// s_axis_tready falls, freezing the whole pipeline until the spare drains.
module pose_compose_and_relate #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // base_x, base_y, base_z, base_heading, arg_x, arg_y, arg_z, arg_angle, zero pad
  input  logic [((6*COORD_WIDTH + 2*ANGLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // op
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // out_x, out_y, out_z, out_angle, zero pad
  output logic [((3*COORD_WIDTH + ANGLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int CW = COORD_WIDTH;
  localparam int AB = ANGLE_BITS;
  localparam int STEPS = pcr_pkg::TRIG_STEPS;
  localparam int TW = pcr_pkg::TRIG_W;
  localparam int RW = pcr_pkg::RES_W;
  localparam int OUT_DATA_W = ((3*CW + AB + 7) / 8) * 8;
  localparam int PW = CW + 1;
  localparam int PRODW = PW + 2;
  localparam int SUM_W = CW + 5;

  localparam int OFF_BY = CW;
  localparam int OFF_BZ = 2*CW;
  localparam int OFF_BH = 3*CW;
  localparam int OFF_AX = 3*CW + AB;
  localparam int OFF_AY = 4*CW + AB;
  localparam int OFF_AZ = 5*CW + AB;
  localparam int OFF_AA = 6*CW + AB;

  localparam logic signed [PW-1:0] ZMAX = {2'b00, {(CW-1){1'b1}}};
  localparam logic signed [PW-1:0] ZMIN = ~ZMAX;
  localparam logic signed [SUM_W-1:0] SMAX = {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SMIN = ~SMAX;

  typedef struct packed {
    pcr_pkg::op_t         op;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic signed [CW-1:0] z;
    logic [AB-1:0]        angle;
  } side_t;

  localparam int SIDE_W = $bits(side_t);

  logic en;

  // Entry stage
  pcr_pkg::op_t         op;
  logic signed [CW-1:0] base_x, base_y, base_z, arg_x, arg_y, arg_z;
  logic [AB-1:0]        base_heading, arg_angle;
  logic signed [PW-1:0] zsum;
  logic signed [TW-1:0] a32;
  logic signed [RW-1:0] zw;
  side_t                side_next;
  pcr_pkg::cordic_t     rot_next;

  logic [STEPS:0]       cvalid;
  pcr_pkg::cordic_t     rot [STEPS+1];
  side_t                side [STEPS+1];

  // Multiplier stages
  logic                 valid_m1, valid_m2;
  side_t                side_m1, side_m2;
  logic signed [PRODW-1:0] pxc, pyc, pxs, pys;

  // Final sum
  logic signed [SUM_W-1:0] sx, sy;
  logic signed [CW-1:0]    out_x, out_y;

  logic [OUT_DATA_W-1:0] out_pack;

  always_comb begin
    op           = pcr_pkg::op_t'(s_axis_tuser);
    base_x       = $signed(s_axis_tdata[0 +: CW]);
    base_y       = $signed(s_axis_tdata[OFF_BY +: CW]);
    base_z       = $signed(s_axis_tdata[OFF_BZ +: CW]);
    base_heading = s_axis_tdata[OFF_BH +: AB];
    arg_x        = $signed(s_axis_tdata[OFF_AX +: CW]);
    arg_y        = $signed(s_axis_tdata[OFF_AY +: CW]);
    arg_z        = $signed(s_axis_tdata[OFF_AZ +: CW]);
    arg_angle    = s_axis_tdata[OFF_AA +: AB];

    side_next.op = op;
    if (op == pcr_pkg::OP_RELATE) begin
      side_next.px    = PW'(arg_x) - PW'(base_x);
      side_next.py    = PW'(arg_y) - PW'(base_y);
      side_next.ox    = '0;
      side_next.oy    = '0;
      zsum            = PW'(arg_z) - PW'(base_z);
      side_next.angle = arg_angle - base_heading;
    end else begin
      side_next.px    = PW'(arg_x);
      side_next.py    = PW'(arg_y);
      side_next.ox    = base_x;
      side_next.oy    = base_y;
      zsum            = PW'(arg_z) + PW'(base_z);
      side_next.angle = base_heading + arg_angle;
    end
    if (zsum > ZMAX) begin
      side_next.z = ZMAX[CW-1:0];
    end else if (zsum < ZMIN) begin
      side_next.z = ZMIN[CW-1:0];
    end else begin
      side_next.z = zsum[CW-1:0];
    end

    // Fold the heading into the right half-plane; the rotated vector is negated later.
    a32 = $signed({base_heading, {(TW-AB){1'b0}}});
    zw  = RW'(a32);
    rot_next.x = pcr_pkg::TRIG_ONE_K;
    rot_next.y = '0;
    if (zw > pcr_pkg::QUARTER) begin
      rot_next.z    = zw - pcr_pkg::HALF;
      rot_next.flip = 1'b1;
    end else if (zw < -pcr_pkg::QUARTER) begin
      rot_next.z    = zw + pcr_pkg::HALF;
      rot_next.flip = 1'b1;
    end else begin
      rot_next.z    = zw;
      rot_next.flip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cvalid[0] <= 1'b0;
    end else if (en) begin
      cvalid[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot[0]  <= rot_next;
      side[0] <= side_next;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    pcr_cordic_stage #(
      .STEP   (k),
      .SIDE_W (SIDE_W)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cvalid[k]),
      .in_rot    (rot[k]),
      .in_side   (side[k]),
      .out_valid (cvalid[k+1]),
      .out_rot   (rot[k+1]),
      .out_side  (side[k+1])
    );
  end

  pcr_mul_q30 #(.VW(PW)) u_mul_xc (
    .clk (clk), .en (en), .v (side[STEPS].px), .c (rot[STEPS].x),
    .flip (rot[STEPS].flip), .p (pxc)
  );
  pcr_mul_q30 #(.VW(PW)) u_mul_yc (
    .clk (clk), .en (en), .v (side[STEPS].py), .c (rot[STEPS].x),
    .flip (rot[STEPS].flip), .p (pyc)
  );
  pcr_mul_q30 #(.VW(PW)) u_mul_xs (
    .clk (clk), .en (en), .v (side[STEPS].px), .c (rot[STEPS].y),
    .flip (rot[STEPS].flip), .p (pxs)
  );
  pcr_mul_q30 #(.VW(PW)) u_mul_ys (
    .clk (clk), .en (en), .v (side[STEPS].py), .c (rot[STEPS].y),
    .flip (rot[STEPS].flip), .p (pys)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_m1 <= 1'b0;
      valid_m2 <= 1'b0;
    end else if (en) begin
      valid_m1 <= cvalid[STEPS];
      valid_m2 <= valid_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_m1 <= side[STEPS];
      side_m2 <= side_m1;
    end
  end

  // Applying a motion rotates by the heading; relating two poses rotates by its negative.
  always_comb begin
    if (side_m2.op == pcr_pkg::OP_RELATE) begin
      sx = SUM_W'(side_m2.ox) + SUM_W'(pxc) + SUM_W'(pys);
      sy = SUM_W'(side_m2.oy) + SUM_W'(pyc) - SUM_W'(pxs);
    end else begin
      sx = SUM_W'(side_m2.ox) + SUM_W'(pxc) - SUM_W'(pys);
      sy = SUM_W'(side_m2.oy) + SUM_W'(pyc) + SUM_W'(pxs);
    end
    if (sx > SMAX) begin
      out_x = SMAX[CW-1:0];
    end else if (sx < SMIN) begin
      out_x = SMIN[CW-1:0];
    end else begin
      out_x = sx[CW-1:0];
    end
    if (sy > SMAX) begin
      out_y = SMAX[CW-1:0];
    end else if (sy < SMIN) begin
      out_y = SMIN[CW-1:0];
    end else begin
      out_y = sy[CW-1:0];
    end
    out_pack = OUT_DATA_W'({side_m2.angle, side_m2.z, out_y, out_x});
  end

  pcr_skid #(.W(OUT_DATA_W)) u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_m2),
    .in_ready  (en),
    .in_data   (out_pack),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  assign s_axis_tready = en;

  a_residual_small: assert property (@(posedge clk) disable iff (rst)
    cvalid[STEPS] |-> (rot[STEPS].z < 33'sd256) && (rot[STEPS].z > -33'sd256))
    else $error("rotation residual did not converge");

  a_frozen_on_stall: assert property (@(posedge clk) disable iff (rst)
    !rst && !s_axis_tready |=> $stable({cvalid, valid_m1, valid_m2}))
    else $error("pipeline moved while stalled");

endmodule

// File: sv/pcr_cordic_stage.sv
module pcr_cordic_stage #(
  parameter int STEP = 0,
  parameter int SIDE_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  pcr_pkg::cordic_t   in_rot,
  input  logic [SIDE_W-1:0]  in_side,
  output logic               out_valid,
  output pcr_pkg::cordic_t   out_rot,
  output logic [SIDE_W-1:0]  out_side
);

  pcr_pkg::cordic_t rot_next;
  logic signed [pcr_pkg::TRIG_W-1:0] dx;
  logic signed [pcr_pkg::TRIG_W-1:0] dy;

  always_comb begin
    dx = in_rot.y >>> STEP;
    dy = in_rot.x >>> STEP;
    rot_next.flip = in_rot.flip;
    if (in_rot.z >= 0) begin
      rot_next.x = in_rot.x - dx;
      rot_next.y = in_rot.y + dy;
      rot_next.z = in_rot.z - pcr_pkg::ATAN_TAB[STEP];
    end else begin
      rot_next.x = in_rot.x + dx;
      rot_next.y = in_rot.y - dy;
      rot_next.z = in_rot.z + pcr_pkg::ATAN_TAB[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rot  <= rot_next;
      out_side <= in_side;
    end
  end

endmodule

// File: sv/pcr_mul_q30.sv
module pcr_mul_q30 #(
  parameter int VW = 33
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [VW-1:0]              v,
  input  logic signed [pcr_pkg::TRIG_W-1:0] c,
  input  logic                              flip,
  output logic signed [VW+1:0]              p
);

  localparam int SPLIT = pcr_pkg::SPLIT;
  localparam int FRAC = pcr_pkg::FRAC;
  localparam int TW = pcr_pkg::TRIG_W;
  localparam int MAG_W = (VW > SPLIT + 1) ? VW : SPLIT + 1;
  localparam int HI_W = MAG_W - SPLIT;
  localparam int A_W = HI_W + TW;
  localparam int B_W = SPLIT + TW;
  localparam int S_W = B_W + 1;
  localparam int LO_A = FRAC - SPLIT;
  localparam int Q_W = VW + 1;
  localparam logic [S_W-1:0] ROUND = S_W'(1) << (FRAC - 1);

  logic [VW-1:0]    v_mag;
  logic [MAG_W-1:0] m;
  logic [TW-1:0]    n;
  logic             neg;
  logic [A_W-1:0]   a_next;
  logic [B_W-1:0]   b_next;

  logic [A_W-1:0]   a;
  logic [B_W-1:0]   b;
  logic             neg_r;

  logic [S_W-1:0]   low_sum;
  logic [Q_W-1:0]   q;
  logic signed [VW+1:0] p_next;

  // First half: magnitudes and two partial products.
  always_comb begin
    v_mag  = v[VW-1] ? VW'(-v) : VW'(v);
    m      = MAG_W'(v_mag);
    n      = c[TW-1] ? TW'(-c) : TW'(c);
    neg    = v[VW-1] ^ c[TW-1] ^ flip;
    a_next = A_W'(m[MAG_W-1:SPLIT]) * A_W'(n);
    b_next = B_W'(m[SPLIT-1:0]) * B_W'(n);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a     <= a_next;
      b     <= b_next;
      neg_r <= neg;
    end
  end

  // Second half: join the partial products, round half away from zero.
  always_comb begin
    low_sum = S_W'({a[LO_A-1:0], {SPLIT{1'b0}}}) + S_W'(b) + ROUND;
    q       = Q_W'(a >> LO_A) + Q_W'(low_sum >> FRAC);
    p_next  = neg_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= p_next;
    end
  end

endmodule

// File: sv/pcr_skid.sv
module pcr_skid #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         main_valid;
  logic         spare_valid;
  logic [W-1:0] main_data;
  logic [W-1:0] spare_data;
  logic         push;
  logic         main_free;

  assign in_ready  = !spare_valid;
  assign push      = in_valid && in_ready;
  assign main_free = out_ready || !main_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (main_free) begin
      main_valid  <= spare_valid || push;
      spare_valid <= 1'b0;
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_data <= spare_valid ? spare_data : in_data;
    end
    if (push) begin
      spare_data <= in_data;
    end
  end

  a_spare_needs_main: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> main_valid)
    else $error("spare entry held while output register is empty");

  a_spare_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(spare_valid) |-> $past(main_valid && !out_ready))
    else $error("spare entry filled without an output stall");

endmodule

// File: bench/pose_result_checker.sv
`timescale 1ns / 100ps

module pose_result_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_ready,
  input  logic [223:0] in_data,
  input  logic         in_op,
  input  logic         out_valid,
  input  logic         out_ready,
  input  logic [111:0] out_data,
  output int           failures,
  output int           outstanding
);

  // Members listed from the highest bits down, so base_x sits in the lowest bits.
  typedef struct packed {
    logic [15:0]        arg_angle;
    logic signed [31:0] arg_z;
    logic signed [31:0] arg_y;
    logic signed [31:0] arg_x;
    logic [15:0]        base_heading;
    logic signed [31:0] base_z;
    logic signed [31:0] base_y;
    logic signed [31:0] base_x;
  } pose_item_t;

  typedef struct packed {
    logic [15:0]        angle;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } pose_result_t;

  localparam int STEPS = 30;
  localparam longint GAIN_ONE = 652032874;
  localparam longint QUARTER_TURN = 64'sd1 << 30;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam int PRINT_LIMIT = 50;

  // Arctangent of 2^-i in 32-bit binary-angle units.
  localparam longint ATAN_UNITS [STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  pose_result_t expected_poses [$];

  initial begin
    failures = 0;
    outstanding = 0;
  end

  function automatic void heading_sincos(input logic [15:0] heading, output longint cs,
                                         output longint sn);
    longint x, y, z, dx, dy;
    logic flip;
    x = GAIN_ONE;
    y = 0;
    flip = 1'b0;
    z = longint'($signed({heading, 16'h0000}));
    // Fold the angle into the right half-plane; the results are negated back.
    if (z > QUARTER_TURN) begin
      z = z - 2 * QUARTER_TURN;
      flip = 1'b1;
    end else if (z < -QUARTER_TURN) begin
      z = z + 2 * QUARTER_TURN;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_UNITS[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_UNITS[i];
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  // Coordinate times Q2.30 factor, rounded half away from zero.
  function automatic longint scale_q30(input longint v, input longint c);
    logic neg;
    logic [63:0] m, n;
    logic [127:0] prod;
    longint q;
    neg = (v < 0) != (c < 0);
    m = (v < 0) ? -v : v;
    n = (c < 0) ? -c : c;
    prod = {64'd0, m} * {64'd0, n} + (128'd1 << 29);
    q = longint'(prod >> 30);
    return neg ? -q : q;
  endfunction

  function automatic logic signed [31:0] clamp_coord(input longint v);
    if (v > COORD_MAX) return 32'sh7FFF_FFFF;
    if (v < COORD_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic pose_result_t compose_or_relate(input pcr_pkg::op_t op,
                                                     input pose_item_t item);
    pose_result_t r;
    longint cs, sn, bx, by, bz, ax, ay, az, dx, dy;
    heading_sincos(item.base_heading, cs, sn);
    bx = item.base_x;
    by = item.base_y;
    bz = item.base_z;
    ax = item.arg_x;
    ay = item.arg_y;
    az = item.arg_z;
    if (op == pcr_pkg::OP_APPLY) begin
      r.x = clamp_coord(bx + scale_q30(ax, cs) - scale_q30(ay, sn));
      r.y = clamp_coord(by + scale_q30(ax, sn) + scale_q30(ay, cs));
      r.z = clamp_coord(bz + az);
      r.angle = item.base_heading + item.arg_angle;
    end else begin
      dx = ax - bx;
      dy = ay - by;
      r.x = clamp_coord(scale_q30(dx, cs) + scale_q30(dy, sn));
      r.y = clamp_coord(scale_q30(dy, cs) - scale_q30(dx, sn));
      r.z = clamp_coord(az - bz);
      r.angle = item.arg_angle - item.base_heading;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (failures < PRINT_LIMIT) begin
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    failures++;
  endtask

  always @(posedge clk) begin
    pose_result_t got, want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_poses.size() == 0) begin
          report_mismatch("result transfer with nothing pending", got.x, 0);
        end else begin
          want = expected_poses.pop_front();
          if (got.x !== want.x) report_mismatch("out_x", got.x, want.x);
          if (got.y !== want.y) report_mismatch("out_y", got.y, want.y);
          if (got.z !== want.z) report_mismatch("out_z", got.z, want.z);
          if (got.angle !== want.angle) report_mismatch("out_angle", got.angle, want.angle);
        end
      end
      if (in_valid && in_ready) begin
        expected_poses.push_back(compose_or_relate(pcr_pkg::op_t'(in_op), in_data));
      end
    end
    outstanding <= expected_poses.size();
  end

endmodule

// File: bench/tb_pose_compose_and_relate.sv
`timescale 1ns / 100ps

module tb_pose_compose_and_relate;

  localparam int RANDOM_ITEMS = 1500;
  localparam int DRAIN_CYCLES = 40;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [223:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;
  int           failures;
  int           outstanding;
  bit           sender_calm;
  bit           receiver_calm;

  pose_compose_and_relate u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  pose_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .in_op      (s_axis_tuser),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .failures   (failures),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("FAIL pose_compose_and_relate");
    $finish;
  end

  // Calm stretches leave one side without any idle cycles for a while.
  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2: return r;
      3:       return 32'h7FFF_FFFF - $urandom_range(0, 255);
      4:       return 32'h8000_0000 + $urandom_range(0, 255);
      default: return {{10{r[21]}}, r[21:0]};
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    logic [15:0] r;
    r = $urandom();
    if ($urandom_range(0, 3) == 0) begin
      // Near the quadrant boundaries, where the folding of the angle changes.
      return {r[15:14], 14'h0000} + 16'($signed(r[3:0]));
    end
    return r;
  endfunction

  task automatic send_item(input pcr_pkg::op_t op, input logic [31:0] bx, input logic [31:0] by,
                           input logic [31:0] bz, input logic [15:0] bh, input logic [31:0] ax,
                           input logic [31:0] ay, input logic [31:0] az, input logic [15:0] aa);
    int gap;
    if ($urandom_range(0, 40) == 0) sender_calm = !sender_calm;
    gap = draw_wait(sender_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {aa, az, ay, ax, bh, bz, by, bx};
    s_axis_tuser <= op;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  initial begin
    int stall;
    m_axis_tready = 1'b0;
    receiver_calm = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 40) == 0) receiver_calm = !receiver_calm;
      stall = draw_wait(receiver_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    logic [15:0] headings [10];
    pcr_pkg::op_t op;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    sender_calm = 1'b0;
    headings = '{16'h0000, 16'h0001, 16'h2000, 16'h3FFF, 16'h4000, 16'h4001,
                 16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_item(pcr_pkg::OP_APPLY, 32'h0, 32'h0, 32'h0, 16'h0000, 32'h0, 32'h0, 32'h0, 16'h0000);
    // Unit forward and double side motion at each interesting heading.
    foreach (headings[i]) begin
      send_item(pcr_pkg::OP_APPLY, 32'h0001_8000, 32'hFFFE_0000, 32'h0, headings[i],
                32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 16'h1000);
    end
    // Position saturation upward and downward.
    send_item(pcr_pkg::OP_APPLY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 16'hFFFF);
    send_item(pcr_pkg::OP_APPLY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h4000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0002);
    send_item(pcr_pkg::OP_APPLY, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'h8000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'h8000);
    // Heading wraps past a full turn.
    send_item(pcr_pkg::OP_APPLY, 32'h0, 32'h0, 32'h0, 16'hFFFF, 32'h0, 32'h0, 32'h0, 16'h0002);
    send_item(pcr_pkg::OP_RELATE, 32'h0, 32'h0, 32'h0, 16'h0000, 32'h0, 32'h0, 32'h0, 16'h0000);
    // Widest differences: both position and height saturate.
    send_item(pcr_pkg::OP_RELATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
    send_item(pcr_pkg::OP_RELATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h2000,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    // Backward turn wraps below zero.
    send_item(pcr_pkg::OP_RELATE, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_4000, 16'h0001,
              32'h0005_0000, 32'h0002_8000, 32'hFFFF_C000, 16'h0000);
    send_item(pcr_pkg::OP_RELATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(pcr_pkg::OP_RELATE, 32'h0, 32'h0, 32'h0, 16'hC000,
              32'h0001_0000, 32'h0001_0000, 32'h0, 16'h4000);

    repeat (RANDOM_ITEMS) begin
      op = pcr_pkg::op_t'($urandom_range(0, 1));
      send_item(op, rand_coord(), rand_coord(), rand_coord(), rand_angle(),
                rand_coord(), rand_coord(), rand_coord(), rand_angle());
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("PASS pose_compose_and_relate");
    end else begin
      $display("FAIL pose_compose_and_relate");
    end
    $finish;
  end

endmodule
